// ----- design/alsc_pkg.sv -----
// shared constants and types for the append log store
package alsc_pkg;

  // fixed field widths of the request and response channels
  localparam int OP_BITS      = 2;
  localparam int KEY_BITS     = 4;
  localparam int PAYLOAD_BITS = 32;

  // default store geometry
  localparam int SLOT_COUNT_DEF = 64;
  localparam int KEY_COUNT_DEF  = 16;
  localparam int DATA_BITS_DEF  = 32;

  // operation codes
  localparam logic [OP_BITS-1:0] OP_SAVE  = 2'd0;
  localparam logic [OP_BITS-1:0] OP_FIND  = 2'd1;
  localparam logic [OP_BITS-1:0] OP_CLEAR = 2'd2;

  // result handed from the sequencer to the response stage
  typedef struct packed {
    logic                    found;
    logic [PAYLOAD_BITS-1:0] stored_payload;
    logic                    compacted;
  } alsc_result_t;

endpackage

// ----- design/alsc_if.sv -----
// request and response channel interfaces of the append log store

interface alsc_req_if;
  logic                               valid;
  logic                               ready;
  logic [alsc_pkg::OP_BITS-1:0]       operation;
  logic [alsc_pkg::KEY_BITS-1:0]      lamp_id;
  logic [alsc_pkg::PAYLOAD_BITS-1:0]  payload;

  modport source (output valid, operation, lamp_id, payload, input ready);
  modport sink   (input valid, operation, lamp_id, payload, output ready);
endinterface

interface alsc_rsp_if;
  logic                               valid;
  logic                               ready;
  logic                               found;
  logic [alsc_pkg::PAYLOAD_BITS-1:0]  stored_payload;
  logic                               compacted;

  modport source (output valid, found, stored_payload, compacted, input ready);
  modport sink   (input valid, found, stored_payload, compacted, output ready);
endinterface

// ----- design/append_log_store_with_compaction_core.sv -----
// Append log store with compaction. Each request transaction (save, find,
// clear) gives exactly one response transaction. Entries live in a slot log
// memory of SLOT_COUNT words plus a per key table holding the slot of each
// key's newest entry; both are single write, single registered read memories
// and every operation walks them one access per cycle. A save into a store
// with room appends the entry, and a find reads the key table, then the slot
// log. A save into a full store compacts first: a gather pass reads every
// surviving key's newest payload into the key table, then a rewrite pass
// appends the survivors from slot 0 in key order, and the new entry is
// appended after them. A clear needs no memory sweep, since only slots
// below the fill count are ever read. A new request is taken while the
// previous response still waits in the output register.
module append_log_store_with_compaction_core #(
  parameter int SLOT_COUNT = alsc_pkg::SLOT_COUNT_DEF,
  parameter int KEY_COUNT  = alsc_pkg::KEY_COUNT_DEF,
  parameter int DATA_BITS  = alsc_pkg::DATA_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  alsc_req_if.sink   req,
  alsc_rsp_if.source rsp
);

  import alsc_pkg::*;

  localparam int SLOT_ADDR_BITS = $clog2(SLOT_COUNT);
  localparam int KEY_ADDR_BITS  = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;
  localparam int SLOT_W         = KEY_BITS + DATA_BITS;
  localparam int KTAB_W         = SLOT_ADDR_BITS + DATA_BITS;

  logic                      res_valid;
  logic                      res_ready;
  alsc_result_t              res;

  logic                      slot_we;
  logic [SLOT_ADDR_BITS-1:0] slot_waddr;
  logic [SLOT_W-1:0]         slot_wdata;
  logic [SLOT_ADDR_BITS-1:0] slot_raddr;
  logic [SLOT_W-1:0]         slot_rdata;
  logic                      ktab_we;
  logic [KEY_ADDR_BITS-1:0]  ktab_waddr;
  logic [KTAB_W-1:0]         ktab_wdata;
  logic [KEY_ADDR_BITS-1:0]  ktab_raddr;
  logic [KTAB_W-1:0]         ktab_rdata;

  logic                      out_valid;
  alsc_result_t              out_res;

  alsc_seq #(
    .SLOT_COUNT     (SLOT_COUNT),
    .KEY_COUNT      (KEY_COUNT),
    .DATA_BITS      (DATA_BITS),
    .SLOT_ADDR_BITS (SLOT_ADDR_BITS),
    .KEY_ADDR_BITS  (KEY_ADDR_BITS)
  ) u_seq (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .res_valid  (res_valid),
    .res        (res),
    .res_ready  (res_ready),
    .slot_we    (slot_we),
    .slot_waddr (slot_waddr),
    .slot_wdata (slot_wdata),
    .slot_raddr (slot_raddr),
    .slot_rdata (slot_rdata),
    .ktab_we    (ktab_we),
    .ktab_waddr (ktab_waddr),
    .ktab_wdata (ktab_wdata),
    .ktab_raddr (ktab_raddr),
    .ktab_rdata (ktab_rdata)
  );

  // slot log: key and payload of every appended entry
  alsc_ram #(
    .DEPTH     (SLOT_COUNT),
    .ADDR_BITS (SLOT_ADDR_BITS),
    .WIDTH     (SLOT_W)
  ) u_slot_ram (
    .clk   (clk),
    .we    (slot_we),
    .waddr (slot_waddr),
    .wdata (slot_wdata),
    .raddr (slot_raddr),
    .rdata (slot_rdata)
  );

  // key table: newest slot per key
  alsc_ram #(
    .DEPTH     (KEY_COUNT),
    .ADDR_BITS (KEY_ADDR_BITS),
    .WIDTH     (KTAB_W)
  ) u_key_ram (
    .clk   (clk),
    .we    (ktab_we),
    .waddr (ktab_waddr),
    .wdata (ktab_wdata),
    .raddr (ktab_raddr),
    .rdata (ktab_rdata)
  );

  // response output register
  assign res_ready = !out_valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res <= res;
    end
  end

  assign rsp.valid          = out_valid;
  assign rsp.found          = out_res.found;
  assign rsp.stored_payload = out_res.stored_payload;
  assign rsp.compacted      = out_res.compacted;

endmodule

// ----- design/alsc_ram.sv -----
// simple dual port memory, one write and one registered read per cycle
module alsc_ram #(
  parameter int DEPTH     = 64,
  parameter int ADDR_BITS = 6,
  parameter int WIDTH     = 36
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [ADDR_BITS-1:0] waddr,
  input  logic [WIDTH-1:0]     wdata,
  input  logic [ADDR_BITS-1:0] raddr,
  output logic [WIDTH-1:0]     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ----- design/alsc_seq.sv -----
// operation sequencer: append, lookup, clear and two pass compaction
module alsc_seq #(
  parameter int SLOT_COUNT     = alsc_pkg::SLOT_COUNT_DEF,
  parameter int KEY_COUNT      = alsc_pkg::KEY_COUNT_DEF,
  parameter int DATA_BITS      = alsc_pkg::DATA_BITS_DEF,
  parameter int SLOT_ADDR_BITS = $clog2(SLOT_COUNT),
  parameter int KEY_ADDR_BITS  = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1
) (
  input  logic                                   clk,
  input  logic                                   rst,
  alsc_req_if.sink                               req,
  output logic                                   res_valid,
  output alsc_pkg::alsc_result_t                 res,
  input  logic                                   res_ready,
  // slot log memory
  output logic                                   slot_we,
  output logic [SLOT_ADDR_BITS-1:0]              slot_waddr,
  output logic [alsc_pkg::KEY_BITS+DATA_BITS-1:0] slot_wdata,
  output logic [SLOT_ADDR_BITS-1:0]              slot_raddr,
  input  logic [alsc_pkg::KEY_BITS+DATA_BITS-1:0] slot_rdata,
  // per key table: newest slot and compaction holding field
  output logic                                   ktab_we,
  output logic [KEY_ADDR_BITS-1:0]               ktab_waddr,
  output logic [SLOT_ADDR_BITS+DATA_BITS-1:0]    ktab_wdata,
  output logic [KEY_ADDR_BITS-1:0]               ktab_raddr,
  input  logic [SLOT_ADDR_BITS+DATA_BITS-1:0]    ktab_rdata
);

  import alsc_pkg::*;

  localparam int FILL_BITS = $clog2(SLOT_COUNT + 1);
  localparam int CNT_BITS  = $clog2(KEY_COUNT + 1);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FIND_TAB,
    ST_FIND_SLOT,
    ST_FIND_DATA,
    ST_P1_TAB,
    ST_P1_SLOT,
    ST_P1_WB,
    ST_P2_TAB,
    ST_P2_WR,
    ST_APPEND,
    ST_DONE
  } state_t;

  state_t                    state;
  logic [KEY_BITS-1:0]       key_raw;
  logic [KEY_ADDR_BITS-1:0]  key_idx;
  logic [DATA_BITS-1:0]      data;
  logic [FILL_BITS-1:0]      fill;
  logic [CNT_BITS-1:0]       cnt;
  logic [KEY_COUNT-1:0]      seen;
  logic [KEY_COUNT-1:0]      keep;
  logic                      res_found;
  logic [DATA_BITS-1:0]      res_data;
  logic                      res_comp;

  logic                      req_key_ok;
  logic [KEY_ADDR_BITS-1:0]  req_key_idx;
  logic [KEY_COUNT-1:0]      keep_init;
  logic [KEY_ADDR_BITS-1:0]  cnt_idx;
  logic                      cnt_end;
  logic                      store_full;
  logic [SLOT_ADDR_BITS-1:0] ktab_slot;
  logic [DATA_BITS-1:0]      ktab_data;
  logic [DATA_BITS-1:0]      slot_data_rd;

  // request decode and field views
  assign req_key_ok   = (32'(req.lamp_id) < 32'(KEY_COUNT));
  assign req_key_idx  = KEY_ADDR_BITS'(req.lamp_id);
  assign cnt_idx      = cnt[KEY_ADDR_BITS-1:0];
  assign cnt_end      = (cnt == CNT_BITS'(KEY_COUNT));
  assign store_full   = (fill == FILL_BITS'(SLOT_COUNT));
  assign ktab_slot    = ktab_rdata[SLOT_ADDR_BITS+DATA_BITS-1:DATA_BITS];
  assign ktab_data    = ktab_rdata[DATA_BITS-1:0];
  assign slot_data_rd = slot_rdata[DATA_BITS-1:0];

  // survivors of a compaction: every key with an entry except the one being saved
  always_comb begin
    for (int i = 0; i < KEY_COUNT; i++) begin
      keep_init[i] = seen[i] && (KEY_ADDR_BITS'(i) != req_key_idx);
    end
  end

  assign req.ready = (state == ST_IDLE) && !rst;
  assign res_valid = (state == ST_DONE);

  always_comb begin
    res.found          = res_found;
    res.stored_payload = PAYLOAD_BITS'(res_data);
    res.compacted      = res_comp;
  end

  // memory port control
  always_comb begin
    slot_we    = 1'b0;
    slot_waddr = fill[SLOT_ADDR_BITS-1:0];
    slot_wdata = {key_raw, data};
    slot_raddr = ktab_slot;
    ktab_we    = 1'b0;
    ktab_waddr = key_idx;
    ktab_wdata = {fill[SLOT_ADDR_BITS-1:0], data};
    ktab_raddr = key_idx;
    unique case (state)
      ST_P1_TAB, ST_P2_TAB: begin
        ktab_raddr = cnt_idx;
      end
      ST_P1_WB: begin
        // park the survivor payload in the key table until the rewrite pass
        ktab_we    = 1'b1;
        ktab_waddr = cnt_idx;
        ktab_wdata = {{SLOT_ADDR_BITS{1'b0}}, slot_data_rd};
      end
      ST_P2_WR: begin
        slot_we    = 1'b1;
        slot_wdata = {KEY_BITS'(cnt), ktab_data};
        ktab_we    = 1'b1;
        ktab_waddr = cnt_idx;
        ktab_wdata = {fill[SLOT_ADDR_BITS-1:0], ktab_data};
      end
      ST_APPEND: begin
        slot_we = 1'b1;
        ktab_we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // sequencer state and result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      seen  <= '0;
      keep  <= '0;
      fill  <= '0;
      cnt   <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (req.valid) begin
            key_raw   <= req.lamp_id;
            key_idx   <= req_key_idx;
            data      <= req.payload[DATA_BITS-1:0];
            res_found <= 1'b0;
            res_data  <= '0;
            res_comp  <= 1'b0;
            unique case (req.operation)
              OP_SAVE: begin
                if (!req_key_ok) begin
                  state <= ST_DONE;
                end else if (store_full) begin
                  keep     <= keep_init;
                  seen     <= '0;
                  fill     <= '0;
                  cnt      <= '0;
                  res_comp <= 1'b1;
                  state    <= ST_P1_TAB;
                end else begin
                  state <= ST_APPEND;
                end
              end
              OP_FIND: begin
                if (req_key_ok && seen[req_key_idx]) begin
                  state <= ST_FIND_TAB;
                end else begin
                  state <= ST_DONE;
                end
              end
              OP_CLEAR: begin
                seen  <= '0;
                fill  <= '0;
                state <= ST_DONE;
              end
              default: begin
                state <= ST_DONE;
              end
            endcase
          end
        end
        ST_FIND_TAB: begin
          state <= ST_FIND_SLOT;
        end
        ST_FIND_SLOT: begin
          state <= ST_FIND_DATA;
        end
        ST_FIND_DATA: begin
          res_found <= 1'b1;
          res_data  <= slot_data_rd;
          state     <= ST_DONE;
        end
        // gather pass: copy each survivor's newest payload into the key table
        ST_P1_TAB: begin
          if (cnt_end) begin
            cnt   <= '0;
            state <= ST_P2_TAB;
          end else if (keep[cnt_idx]) begin
            state <= ST_P1_SLOT;
          end else begin
            cnt <= cnt + CNT_BITS'(1);
          end
        end
        ST_P1_SLOT: begin
          state <= ST_P1_WB;
        end
        ST_P1_WB: begin
          cnt   <= cnt + CNT_BITS'(1);
          state <= ST_P1_TAB;
        end
        // rewrite pass: survivors land from slot 0 up in key order
        ST_P2_TAB: begin
          if (cnt_end) begin
            state <= ST_APPEND;
          end else if (keep[cnt_idx]) begin
            state <= ST_P2_WR;
          end else begin
            cnt <= cnt + CNT_BITS'(1);
          end
        end
        ST_P2_WR: begin
          seen[cnt_idx] <= 1'b1;
          fill          <= fill + FILL_BITS'(1);
          cnt           <= cnt + CNT_BITS'(1);
          state         <= ST_P2_TAB;
        end
        ST_APPEND: begin
          seen[key_idx] <= 1'b1;
          fill          <= fill + FILL_BITS'(1);
          state         <= ST_DONE;
        end
        ST_DONE: begin
          if (res_ready) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // a slot write always finds room
  a_write_room: assert property (@(posedge clk) disable iff (rst)
    (state == ST_APPEND || state == ST_P2_WR) |-> (fill < FILL_BITS'(SLOT_COUNT)))
    else $error("slot write with the store full");

  // compaction starts from an empty store and flags the result
  a_compact_start: assert property (@(posedge clk) disable iff (rst)
    (state == ST_P1_TAB && $past(state) == ST_IDLE) |->
      (fill == '0 && seen == '0 && res_comp))
    else $error("compaction did not start from an empty store");

  // the key being saved never survives its own compaction
  a_skip_key: assert property (@(posedge clk) disable iff (rst)
    (state == ST_P1_TAB || state == ST_P2_TAB) |-> !keep[key_idx])
    else $error("saved key kept by compaction");

  // a lookup only reaches its data read for a key that holds an entry
  a_find_seen: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FIND_DATA) |-> seen[key_idx])
    else $error("lookup of a key with no entry");

endmodule

// ----- tb/append_log_store_with_compaction_core_tb.sv -----
// testbench for the append log store: directed table, then random save/find/clear traffic
`timescale 1ns / 100ps

module append_log_store_with_compaction_core_tb;
  import alsc_pkg::*;

  localparam int SLOT_COUNT = SLOT_COUNT_DEF;
  localparam int KEY_COUNT  = KEY_COUNT_DEF;
  localparam int DATA_BITS  = DATA_BITS_DEF;
  localparam logic [PAYLOAD_BITS-1:0] DATA_MASK =
    (DATA_BITS >= PAYLOAD_BITS) ? '1 : ((PAYLOAD_BITS'(1) << DATA_BITS) - 1);

  // the fourth operation code is not defined by the block
  localparam logic [OP_BITS-1:0] OP_UNUSED = 2'd3;

  localparam int PLAN_ROWS    = 22;
  localparam int RANDOM_ITEMS = 2000;
  localparam int MAX_REPORTS  = 10;
  localparam int HOLD_AT      = 300;
  localparam int HOLD_CYCLES  = 500;
  localparam int DRAIN_CYCLES = 200;
  localparam longint TIMEOUT_NS = 64'd20_000_000;

  typedef struct packed {
    logic [OP_BITS-1:0]      op;
    logic [KEY_BITS-1:0]     key;
    logic [PAYLOAD_BITS-1:0] payload;
    bit                      typed;
    alsc_result_t            result;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst;

  alsc_req_if req_ch ();
  alsc_rsp_if rsp_ch ();

  append_log_store_with_compaction_core dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  always #5 clk = ~clk;

  // shadow copy of the slot log and the per key newest table
  logic [KEY_BITS-1:0]     log_key  [SLOT_COUNT];
  logic [PAYLOAD_BITS-1:0] log_data [SLOT_COUNT];
  int unsigned             log_fill;
  bit                      key_live   [KEY_COUNT];
  int unsigned             key_newest [KEY_COUNT];

  alsc_result_t pending_answers [$];
  int           mismatch_count;
  int           answer_index;
  int           counted_requests;
  bit           sender_streaming;
  plan_row_t    directed_plan [PLAN_ROWS];

  function automatic void store_wipe();
    for (int k = 0; k < KEY_COUNT; k++) begin
      key_live[k]   = 1'b0;
      key_newest[k] = 0;
    end
    log_fill = 0;
  endfunction

  function automatic void store_append(int unsigned key, logic [PAYLOAD_BITS-1:0] data);
    if (log_fill >= SLOT_COUNT || key >= KEY_COUNT) return;
    log_key[log_fill]  = key[KEY_BITS-1:0];
    log_data[log_fill] = data & DATA_MASK;
    key_live[key]      = 1'b1;
    key_newest[key]    = log_fill;
    log_fill++;
  endfunction

  // keep the newest entry of every key but the one being saved, rewrite in key order
  function automatic void compact_store(int unsigned skip_key);
    logic [PAYLOAD_BITS-1:0] keep_data [KEY_COUNT];
    bit                      keep_ok   [KEY_COUNT];
    for (int k = 0; k < KEY_COUNT; k++) begin
      keep_ok[k]   = (k != skip_key) && key_live[k] && (key_newest[k] < SLOT_COUNT);
      keep_data[k] = keep_ok[k] ? log_data[key_newest[k]] : '0;
    end
    store_wipe();
    for (int k = 0; k < KEY_COUNT; k++)
      if (keep_ok[k]) store_append(k, keep_data[k]);
  endfunction

  // answer of the store to one request, updating the shadow state
  function automatic alsc_result_t log_store_answer(logic [OP_BITS-1:0] op,
                                                    logic [KEY_BITS-1:0] key,
                                                    logic [PAYLOAD_BITS-1:0] payload);
    alsc_result_t res;
    int unsigned  k;
    res = '0;
    k   = key;
    case (op)
      OP_SAVE: begin
        if (k < KEY_COUNT) begin
          if (log_fill >= SLOT_COUNT) begin
            compact_store(k);
            res.compacted = 1'b1;
          end
          store_append(k, payload);
        end
      end
      OP_FIND: begin
        if (k < KEY_COUNT && key_live[k] && key_newest[k] < log_fill) begin
          res.found          = 1'b1;
          res.stored_payload = log_data[key_newest[k]] & DATA_MASK;
        end
      end
      OP_CLEAR: store_wipe();
      default: ;
    endcase
    return res;
  endfunction

  function automatic plan_row_t fixed_row(logic [OP_BITS-1:0] op, logic [KEY_BITS-1:0] key,
                                          logic [PAYLOAD_BITS-1:0] payload, logic found,
                                          logic [PAYLOAD_BITS-1:0] value, logic compacted);
    plan_row_t row;
    row.op      = op;
    row.key     = key;
    row.payload = payload;
    row.typed   = 1'b1;
    row.result  = '{found: found, stored_payload: value, compacted: compacted};
    return row;
  endfunction

  function automatic plan_row_t predicted_row(logic [OP_BITS-1:0] op, logic [KEY_BITS-1:0] key,
                                              logic [PAYLOAD_BITS-1:0] payload);
    plan_row_t row;
    row        = fixed_row(op, key, payload, 1'b0, '0, 1'b0);
    row.typed  = 1'b0;
    return row;
  endfunction

  // mostly short gaps, now and then a long one
  function automatic int idle_cycles();
    int r;
    r = $urandom_range(99, 0);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(10, 4);
    return $urandom_range(40, 11);
  endfunction

  function automatic logic [PAYLOAD_BITS-1:0] random_payload();
    int r;
    r = $urandom_range(19, 0);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return $urandom;
  endfunction

  // offer one request transaction and record its answer once accepted
  task automatic send_request(logic [OP_BITS-1:0] op, logic [KEY_BITS-1:0] key,
                              logic [PAYLOAD_BITS-1:0] payload,
                              bit typed = 1'b0, alsc_result_t typed_result = '0);
    int           gap;
    alsc_result_t predicted;
    gap = sender_streaming ? 0 : idle_cycles();
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid     <= 1'b1;
    req_ch.operation <= op;
    req_ch.lamp_id   <= key;
    req_ch.payload   <= payload;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    predicted = log_store_answer(op, key, payload);
    pending_answers.push_back(typed ? typed_result : predicted);
    if (op != OP_UNUSED) counted_requests++;
  endtask

  // stimulus: directed table, then random bursts
  initial begin : request_source
    int                      mode;
    int                      lo;
    int                      hi;
    int                      len;
    int                      r;
    int                      random_start;
    bit                      paused;
    logic [KEY_BITS-1:0]     one_key;
    logic [OP_BITS-1:0]      op;
    logic [KEY_BITS-1:0]     key;

    rst              <= 1'b1;
    req_ch.valid     <= 1'b0;
    req_ch.operation <= OP_SAVE;
    req_ch.lamp_id   <= '0;
    req_ch.payload   <= '0;
    mismatch_count   = 0;
    answer_index     = 0;
    counted_requests = 0;
    sender_streaming = 1'b0;
    paused           = 1'b0;
    store_wipe();

    directed_plan = '{
      fixed_row(OP_FIND, 4'd0, 32'h0, 1'b0, 32'h0, 1'b0),
      fixed_row(OP_FIND, 4'd15, 32'h0, 1'b0, 32'h0, 1'b0),
      fixed_row(OP_SAVE, 4'd0, 32'h0000_0000, 1'b0, 32'h0, 1'b0),
      fixed_row(OP_SAVE, 4'd15, 32'hFFFF_FFFF, 1'b0, 32'h0, 1'b0),
      fixed_row(OP_FIND, 4'd0, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000, 1'b0),
      fixed_row(OP_FIND, 4'd15, 32'h0, 1'b1, 32'hFFFF_FFFF, 1'b0),
      predicted_row(OP_SAVE, 4'd15, 32'h1234_5678),
      predicted_row(OP_FIND, 4'd15, 32'h0),
      fixed_row(OP_UNUSED, 4'd15, 32'hFFFF_FFFF, 1'b0, 32'h0, 1'b0),
      predicted_row(OP_FIND, 4'd15, 32'h0),
      predicted_row(OP_SAVE, 4'd7, 32'hA5A5_A5A5),
      predicted_row(OP_FIND, 4'd7, 32'h0),
      fixed_row(OP_FIND, 4'd3, 32'h0, 1'b0, 32'h0, 1'b0),
      fixed_row(OP_CLEAR, 4'd15, 32'hFFFF_FFFF, 1'b0, 32'h0, 1'b0),
      fixed_row(OP_FIND, 4'd15, 32'h0, 1'b0, 32'h0, 1'b0),
      fixed_row(OP_FIND, 4'd7, 32'h0, 1'b0, 32'h0, 1'b0),
      fixed_row(OP_SAVE, 4'd3, 32'h5A5A_5A5A, 1'b0, 32'h0, 1'b0),
      fixed_row(OP_FIND, 4'd3, 32'h0, 1'b1, 32'h5A5A_5A5A, 1'b0),
      fixed_row(OP_UNUSED, 4'd0, 32'h0, 1'b0, 32'h0, 1'b0),
      predicted_row(OP_SAVE, 4'd8, 32'h8000_0000),
      predicted_row(OP_FIND, 4'd8, 32'h0),
      fixed_row(OP_CLEAR, 4'd0, 32'h0, 1'b0, 32'h0, 1'b0)
    };

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < PLAN_ROWS; i++)
      send_request(directed_plan[i].op, directed_plan[i].key, directed_plan[i].payload,
                   directed_plan[i].typed, directed_plan[i].result);

    random_start = counted_requests;
    while (counted_requests < random_start + RANDOM_ITEMS) begin
      // once, midway, let the store drain completely before going on
      if (!paused && counted_requests >= random_start + RANDOM_ITEMS / 2) begin
        req_ch.valid <= 1'b0;
        while (pending_answers.size() != 0) @(posedge clk);
        paused = 1'b1;
      end
      sender_streaming = ($urandom_range(4, 0) == 0);
      mode = $urandom_range(9, 0);
      if (mode == 0) begin
        // one key fills the whole log, so the compaction keeps nothing
        one_key = KEY_BITS'($urandom_range(KEY_COUNT - 1, 0));
        send_request(OP_CLEAR, KEY_BITS'($urandom_range(15, 0)), random_payload());
        repeat (SLOT_COUNT + $urandom_range(6, 1))
          send_request(OP_SAVE, one_key, random_payload());
        send_request(OP_FIND, one_key, random_payload());
        send_request(OP_FIND, one_key + 4'd1, random_payload());
      end else begin
        if (mode <= 2) begin
          lo = 0;
          hi = KEY_COUNT - 1;
        end else begin
          lo = $urandom_range(KEY_COUNT - 1, 0);
          hi = $urandom_range(KEY_COUNT - 1, lo);
        end
        if ($urandom_range(9, 0) == 0)
          send_request(OP_CLEAR, KEY_BITS'($urandom_range(15, 0)), random_payload());
        len = (mode <= 2) ? $urandom_range(150, 80) : $urandom_range(120, 20);
        repeat (len) begin
          r   = $urandom_range(99, 0);
          key = KEY_BITS'($urandom_range(hi, lo));
          if (mode <= 2) op = (r < 80) ? OP_SAVE : OP_FIND;
          else if (r < 60) op = OP_SAVE;
          else if (r < 94) op = OP_FIND;
          else if (r < 99) op = OP_UNUSED;
          else op = OP_CLEAR;
          // some non-save requests look outside the pool to hit missing keys
          if (op != OP_SAVE && $urandom_range(3, 0) == 0) key = KEY_BITS'($urandom_range(15, 0));
          send_request(op, key, random_payload());
        end
      end
    end

    sender_streaming = 1'b0;
    req_ch.valid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

  // response side: random stalls, streaming stretches and one long hold-off
  initial begin : response_sink
    int stall;
    int streak;
    int taken;
    streak = 0;
    taken  = 0;
    rsp_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (taken == HOLD_AT) begin
        stall = HOLD_CYCLES;
      end else if (streak > 0) begin
        stall = 0;
        streak--;
      end else begin
        stall = idle_cycles();
        if ($urandom_range(19, 0) == 0) streak = 40;
      end
      if (stall > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
      @(posedge clk);
      while (!rsp_ch.valid) @(posedge clk);
      taken++;
    end
  end

  // compare every response transaction with the oldest pending answer
  always @(posedge clk) begin : answer_check
    alsc_result_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      answer_index++;
      if (pending_answers.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("answer %0d with nothing pending: found=%0b payload=%08h compacted=%0b",
                   answer_index, rsp_ch.found, rsp_ch.stored_payload, rsp_ch.compacted);
      end else begin
        want = pending_answers.pop_front();
        if (rsp_ch.found !== want.found || rsp_ch.stored_payload !== want.stored_payload ||
            rsp_ch.compacted !== want.compacted) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("answer %0d: expected found=%0b payload=%08h compacted=%0b, got %0b %08h %0b",
                     answer_index, want.found, want.stored_payload, want.compacted,
                     rsp_ch.found, rsp_ch.stored_payload, rsp_ch.compacted);
        end
      end
    end
  end

  // hard stop in case the store hangs
  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("Mismatches found");
    $finish;
  end

endmodule

// ----- files.f -----
design/alsc_pkg.sv
design/alsc_if.sv
design/alsc_ram.sv
design/alsc_seq.sv
design/append_log_store_with_compaction_core.sv
tb/append_log_store_with_compaction_core_tb.sv
